FILE: sv/cbf_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cbf_pkg;

  // Field widths fixed by the word format
  localparam int unsigned OpW    = 3;
  localparam int unsigned ByteW  = 8;
  localparam int unsigned CountW = 11;

  // Operation codes
  typedef enum logic [OpW-1:0] {
    OP_ENQ   = 3'd0,
    OP_DEQ   = 3'd1,
    OP_PEEK  = 3'd2,
    OP_SKIP  = 3'd3,
    OP_CLEAR = 3'd4
  } cbf_op_e;

  // Occupancy figures reported with every result word
  typedef struct packed {
    logic [CountW-1:0] used;
    logic [CountW-1:0] free;
    logic [CountW-1:0] span_wr;
    logic [CountW-1:0] span_rd;
  } cbf_status_t;

endpackage

`default_nettype wire

FILE: sv/cbf_in_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface cbf_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  operation;
  logic [7:0]  byte_in;
  logic [10:0] amount;

  modport source (output valid, output operation, output byte_in, output amount,
                  input ready);
  modport sink (input valid, input operation, input byte_in, input amount,
                output ready);
endinterface

interface cbf_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  byte_out;
  logic [10:0] done_count;
  logic [10:0] used_count;
  logic [10:0] free_count;
  logic [10:0] contiguous_write;
  logic [10:0] contiguous_read;

  modport source (output valid, output byte_out, output done_count, output used_count,
                  output free_count, output contiguous_write, output contiguous_read,
                  input ready);
  modport sink (input valid, input byte_out, input done_count, input used_count,
                input free_count, input contiguous_write, input contiguous_read,
                output ready);
endinterface

`default_nettype wire

FILE: sv/cbf_mem.sv
`timescale 1ns / 1ps
`default_nettype none

module cbf_mem import cbf_pkg::*; #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [ByteW-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [ByteW-1:0]         rdata_o
);

  logic [ByteW-1:0] mem_q [DEPTH];

  // Simple dual port store, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

FILE: sv/cbf_ptr.sv
`timescale 1ns / 1ps
`default_nettype none

module cbf_ptr import cbf_pkg::*; #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     accept_i,
  input  wire cbf_op_e                  op_i,
  input  wire logic [CountW-1:0]        amount_i,
  output logic                          mem_we_o,
  output logic [$clog2(DEPTH)-1:0]      mem_waddr_o,
  output logic                          mem_re_o,
  output logic [$clog2(DEPTH)-1:0]      mem_raddr_o,
  output logic                          hit_o,
  output logic [CountW-1:0]             done_o,
  output cbf_status_t                   status_o
);

  localparam int unsigned AW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH + 1);
  localparam int unsigned XW = (CW > CountW) ? CW : CountW;
  localparam int unsigned SW = CW + 1;

  logic [AW-1:0] rd_q, rd_d, wr_q, wr_d;
  logic [CW-1:0] fill_q, fill_d;

  logic          full, empty, peek_ok;
  logic [XW-1:0] fill_x, amt_x, skip_x, free_x, used_x, cw_x, cr_x;
  logic [CW-1:0] skip_n, span_wr, span_rd;
  logic [AW-1:0] rd_inc, wr_inc, peek_addr, skip_addr;

  // Index plus offset, wrapped once (exact only while the sum stays below twice the depth)
  function automatic logic [AW-1:0] adv(logic [AW-1:0] idx, logic [CW-1:0] by);
    logic [SW-1:0] s;
    s = SW'(idx) + SW'(by);
    if (s >= SW'(DEPTH)) begin
      s = s - SW'(DEPTH);
    end
    return AW'(s);
  endfunction

  assign full    = (fill_q == CW'(DEPTH));
  assign empty   = (fill_q == '0);
  assign fill_x  = XW'(fill_q);
  assign amt_x   = XW'(amount_i);
  assign peek_ok = (amt_x < fill_x);
  assign skip_x  = peek_ok ? amt_x : fill_x;
  assign skip_n  = CW'(skip_x);

  assign rd_inc    = adv(rd_q, CW'(1));
  assign wr_inc    = adv(wr_q, CW'(1));
  assign peek_addr = adv(rd_q, CW'(amount_i));
  assign skip_addr = adv(rd_q, skip_n);

  // Operation decode and next pointer state
  always_comb begin
    rd_d        = rd_q;
    wr_d        = wr_q;
    fill_d      = fill_q;
    mem_we_o    = 1'b0;
    mem_re_o    = 1'b0;
    mem_waddr_o = wr_q;
    mem_raddr_o = rd_q;
    hit_o       = 1'b0;
    done_o      = '0;
    if (accept_i) begin
      unique case (op_i)
        OP_ENQ: begin
          if (!full) begin
            mem_we_o = 1'b1;
            wr_d     = wr_inc;
            fill_d   = fill_q + CW'(1);
            done_o   = CountW'(1);
          end
        end
        OP_DEQ: begin
          if (!empty) begin
            mem_re_o = 1'b1;
            hit_o    = 1'b1;
            rd_d     = rd_inc;
            fill_d   = fill_q - CW'(1);
            done_o   = CountW'(1);
          end
        end
        OP_PEEK: begin
          if (peek_ok) begin
            mem_re_o    = 1'b1;
            mem_raddr_o = peek_addr;
            hit_o       = 1'b1;
            done_o      = CountW'(1);
          end
        end
        OP_SKIP: begin
          if (skip_n != '0) begin
            rd_d   = skip_addr;
            fill_d = fill_q - skip_n;
          end
          done_o = skip_x[CountW-1:0];
        end
        OP_CLEAR: begin
          rd_d   = '0;
          wr_d   = '0;
          fill_d = '0;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q   <= '0;
      wr_q   <= '0;
      fill_q <= '0;
    end else begin
      rd_q   <= rd_d;
      wr_q   <= wr_d;
      fill_q <= fill_d;
    end
  end

  // Spans before wrap, from the current pointers
  always_comb begin
    if (full) begin
      span_wr = '0;
    end else if (rd_q <= wr_q) begin
      span_wr = CW'(DEPTH) - CW'(wr_q);
    end else begin
      span_wr = CW'(rd_q) - CW'(wr_q);
    end
    if (empty) begin
      span_rd = '0;
    end else if (rd_q < wr_q) begin
      span_rd = CW'(wr_q) - CW'(rd_q);
    end else begin
      span_rd = CW'(DEPTH) - CW'(rd_q);
    end
  end

  assign used_x = fill_x;
  assign free_x = XW'(CW'(DEPTH) - fill_q);
  assign cw_x   = XW'(span_wr);
  assign cr_x   = XW'(span_rd);

  assign status_o.used    = used_x[CountW-1:0];
  assign status_o.free    = free_x[CountW-1:0];
  assign status_o.span_wr = cw_x[CountW-1:0];
  assign status_o.span_rd = cr_x[CountW-1:0];

endmodule

`default_nettype wire

FILE: sv/circular_byte_fifo_top.sv
// Byte ring buffer of DEPTH slots. Each input word carries one operation
// (enqueue, dequeue, peek at offset, skip, clear) and yields exactly one
// result word with the byte read, the bytes done and the used, free and
// contiguous counts after the operation. One word is taken every clock
// cycle while the result side keeps up. A result word passes through stage 1
// and then the output register: the byte store read is registered on the
// accepting edge into stage 1, and the output register follows it.
// The store has one write and one read port, so a dequeue straight after
// an enqueue of the same slot sees the new byte. Counts wider than 11
// bits (DEPTH of 2048 or more) are reported modulo 2048.
// No clearing pass after reset.
`timescale 1ns / 1ps
`default_nettype none

module circular_byte_fifo_top import cbf_pkg::*; #(
  parameter int unsigned DEPTH = 1024
) (
  input wire logic clk_i,
  input wire logic rst_ni,
  cbf_in_if.sink   in_i,
  cbf_out_if.source out_o
);

  localparam int unsigned AW = $clog2(DEPTH);

  logic              accept;
  logic              mem_we, mem_re, hit;
  logic [AW-1:0]     mem_waddr, mem_raddr;
  logic [ByteW-1:0]  rdata;
  logic [CountW-1:0] done;
  cbf_status_t       status;

  logic              s1_valid_q, s1_valid_d, s1_hit_q;
  logic [CountW-1:0] s1_done_q;
  logic              s1_adv;

  logic              out_valid_q, out_valid_d;
  logic [ByteW-1:0]  out_byte_q;
  logic [CountW-1:0] out_done_q;
  cbf_status_t       out_status_q;

  assign s1_adv     = s1_valid_q && (!out_valid_q || out_o.ready);
  assign in_i.ready = !s1_valid_q || s1_adv;
  assign accept     = in_i.valid && in_i.ready;

  cbf_ptr #(.DEPTH(DEPTH)) u_ptr (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .accept_i    (accept),
    .op_i        (cbf_op_e'(in_i.operation)),
    .amount_i    (in_i.amount),
    .mem_we_o    (mem_we),
    .mem_waddr_o (mem_waddr),
    .mem_re_o    (mem_re),
    .mem_raddr_o (mem_raddr),
    .hit_o       (hit),
    .done_o      (done),
    .status_o    (status)
  );

  cbf_mem #(.DEPTH(DEPTH)) u_mem (
    .clk_i   (clk_i),
    .we_i    (mem_we),
    .waddr_i (mem_waddr),
    .wdata_i (in_i.byte_in),
    .re_i    (mem_re),
    .raddr_i (mem_raddr),
    .rdata_o (rdata)
  );

  // Stage 1: waits for the store read; pointers already hold its outcome
  assign s1_valid_d = accept || (s1_valid_q && !s1_adv);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= s1_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s1_hit_q  <= hit;
      s1_done_q <= done;
    end
  end

  // Output register
  assign out_valid_d = s1_adv || (out_valid_q && !out_o.ready);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv) begin
      out_byte_q   <= s1_hit_q ? rdata : '0;
      out_done_q   <= s1_done_q;
      out_status_q <= status;
    end
  end

  assign out_o.valid            = out_valid_q;
  assign out_o.byte_out         = out_byte_q;
  assign out_o.done_count       = out_done_q;
  assign out_o.used_count       = out_status_q.used;
  assign out_o.free_count       = out_status_q.free;
  assign out_o.contiguous_write = out_status_q.span_wr;
  assign out_o.contiguous_read  = out_status_q.span_rd;

endmodule

`default_nettype wire

FILE: sv/cbf_chk.sv
`timescale 1ns / 1ps
`default_nettype none

module cbf_chk #(
  parameter int unsigned DEPTH = 1024
) (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [7:0]  byte_out_i,
  input wire logic [10:0] used_i,
  input wire logic [10:0] free_i,
  input wire logic [10:0] span_wr_i,
  input wire logic [10:0] span_rd_i
);

  localparam logic [10:0] DepthLow = 11'(DEPTH);
  localparam bit          Narrow   = (DEPTH <= 1024);

  // A stalled result word stays offered and unchanged
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(byte_out_i) && $stable(used_i))
    else $error("result word dropped or changed while stalled");

  // Used and free always add up to the depth
  a_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (11'(used_i + free_i) == DepthLow))
    else $error("used plus free differs from depth");

  // Spans never exceed what is held or free
  a_span: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && Narrow |-> (span_rd_i <= used_i) && (span_wr_i <= free_i))
    else $error("contiguous span exceeds count");

  // Empty or full buffers report no span on that side
  a_edge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && Narrow && ((used_i == '0) || (free_i == '0)) |->
      ((used_i != '0) || (span_rd_i == '0)) && ((free_i != '0) || (span_wr_i == '0)))
    else $error("non-zero span on empty or full buffer");

endmodule

bind circular_byte_fifo_top cbf_chk #(.DEPTH(DEPTH)) u_cbf_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .byte_out_i  (out_o.byte_out),
  .used_i      (out_o.used_count),
  .free_i      (out_o.free_count),
  .span_wr_i   (out_o.contiguous_write),
  .span_rd_i   (out_o.contiguous_read)
);

`default_nettype wire

FILE: tb/cbf_result_check.sv
`timescale 1ns / 1ps

// Watches both channels of the byte ring buffer. Every word taken on the
// input side is run through a local copy of the ring to give the result
// word due for it; every result word taken on the output side is checked
// against the oldest of those, field by field.
module cbf_result_check import cbf_pkg::*; #(
  parameter int unsigned DEPTH = 1024
) (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  cbf_in_if           in_mon,
  cbf_out_if          out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o,
  output int unsigned compared_o,
  output int unsigned full_refusals_o
);

  typedef struct packed {
    logic [ByteW-1:0]  data;
    logic [CountW-1:0] done;
    cbf_status_t       status;
  } ring_result_t;

  // Local copy of the ring
  logic [ByteW-1:0] ring_mem [DEPTH];
  int unsigned      rd_idx;
  int unsigned      wr_idx;
  int unsigned      level;

  ring_result_t due_q [$];

  // Apply one operation to the local ring; return the result word it gives
  function automatic ring_result_t apply_op(input logic [OpW-1:0] op,
                                            input logic [ByteW-1:0] data,
                                            input logic [CountW-1:0] amt);
    ring_result_t r;
    int unsigned  done;
    r    = '0;
    done = 0;
    case (op)
      OP_ENQ: begin
        if (level < DEPTH) begin
          ring_mem[wr_idx] = data;
          wr_idx = (wr_idx + 1) % DEPTH;
          level++;
          done = 1;
        end
      end
      OP_DEQ: begin
        if (level > 0) begin
          r.data = ring_mem[rd_idx];
          rd_idx = (rd_idx + 1) % DEPTH;
          level--;
          done = 1;
        end
      end
      OP_PEEK: begin
        if (amt < level) begin
          r.data = ring_mem[(rd_idx + amt) % DEPTH];
          done = 1;
        end
      end
      OP_SKIP: begin
        // saturates at the fill level
        done   = (amt < level) ? amt : level;
        rd_idx = (rd_idx + done) % DEPTH;
        level  = level - done;
      end
      OP_CLEAR: begin
        rd_idx = 0;
        wr_idx = 0;
        level  = 0;
      end
      default: ;
    endcase
    r.done        = CountW'(done);
    r.status.used = CountW'(level);
    r.status.free = CountW'(DEPTH - level);
    // free run from the write index up to the end of the store or the front
    if (level >= DEPTH) r.status.span_wr = '0;
    else if (rd_idx <= wr_idx) r.status.span_wr = CountW'(DEPTH - wr_idx);
    else r.status.span_wr = CountW'(rd_idx - wr_idx);
    // held run from the read index up to the end of the store or the rear
    if (level == 0) r.status.span_rd = '0;
    else if (rd_idx < wr_idx) r.status.span_rd = CountW'(wr_idx - rd_idx);
    else r.status.span_rd = CountW'(DEPTH - rd_idx);
    return r;
  endfunction

  // Predict on input words, compare on result words
  always @(posedge clk_i or negedge rst_ni) begin
    ring_result_t want;
    ring_result_t got;
    if (!rst_ni) begin
      rd_idx          = 0;
      wr_idx          = 0;
      level           = 0;
      due_q.delete();
      fail_count_o    <= 0;
      pending_o       <= 0;
      compared_o      <= 0;
      full_refusals_o <= 0;
    end else begin
      if (in_mon.valid && in_mon.ready) begin
        if (in_mon.operation == OP_ENQ && level >= DEPTH) full_refusals_o <= full_refusals_o + 1;
        due_q.push_back(apply_op(in_mon.operation, in_mon.byte_in, in_mon.amount));
      end
      if (out_mon.valid && out_mon.ready) begin
        got.data           = out_mon.byte_out;
        got.done           = out_mon.done_count;
        got.status.used    = out_mon.used_count;
        got.status.free    = out_mon.free_count;
        got.status.span_wr = out_mon.contiguous_write;
        got.status.span_rd = out_mon.contiguous_read;
        compared_o <= compared_o + 1;
        if (due_q.size() == 0) begin
          fail_count_o <= fail_count_o + 1;
          if (fail_count_o < 10)
            $display("%0t: result word with nothing outstanding: byte %02h done %0d used %0d",
                     $realtime, got.data, got.done, got.status.used);
        end else begin
          want = due_q.pop_front();
          if (got.data !== want.data || got.done !== want.done ||
              got.status.used !== want.status.used || got.status.free !== want.status.free ||
              got.status.span_wr !== want.status.span_wr ||
              got.status.span_rd !== want.status.span_rd) begin
            fail_count_o <= fail_count_o + 1;
            if (fail_count_o < 10) begin
              $display("%0t: result word %0d mismatch", $realtime, compared_o);
              $display("  expected byte %02h done %0d used %0d free %0d span_wr %0d span_rd %0d",
                       want.data, want.done, want.status.used, want.status.free,
                       want.status.span_wr, want.status.span_rd);
              $display("  actual   byte %02h done %0d used %0d free %0d span_wr %0d span_rd %0d",
                       got.data, got.done, got.status.used, got.status.free,
                       got.status.span_wr, got.status.span_rd);
            end
          end
        end
      end
      pending_o <= due_q.size();
    end
  end

endmodule

FILE: tb/circular_byte_fifo_top_tb.sv
`timescale 1ns / 1ps

// Drives operation words into the byte ring buffer and random backpressure
// on its result side; the result checker beside the block does the scoring.
module circular_byte_fifo_top_tb;
  import cbf_pkg::*;

  localparam int unsigned DEPTH       = 1024;
  localparam int unsigned WORD_TARGET = 1900;
  localparam int unsigned STALL_LIMIT = 2000;

  // Codes the block does not define; it must leave the ring alone
  localparam logic [OpW-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [OpW-1:0] OP_SPARE_LAST  = 3'd7;

  // Mixes of operations for the random bursts
  localparam int MIX_DRAIN = 0;
  localparam int MIX_EVEN  = 1;
  localparam int MIX_FILL  = 2;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int unsigned src_idle_pct = 0;
  int unsigned snk_idle_pct = 0;
  int unsigned words_sent   = 0;
  int unsigned op_seen [8];
  int unsigned stall_cycles;

  int unsigned fail_count;
  int unsigned pending;
  int unsigned compared;
  int unsigned full_refusals;

  cbf_in_if  in_w ();
  cbf_out_if out_w ();

  circular_byte_fifo_top #(.DEPTH(DEPTH)) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_w),
    .out_o  (out_w)
  );

  cbf_result_check #(.DEPTH(DEPTH)) u_result_check (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_mon          (in_w),
    .out_mon         (out_w),
    .fail_count_o    (fail_count),
    .pending_o       (pending),
    .compared_o      (compared),
    .full_refusals_o (full_refusals)
  );

  // 8 ns clock
  always begin
    clk_i = 1'b1;
    #4;
    clk_i = 1'b0;
    #4;
  end

  // Result side backpressure
  initial out_w.ready = 1'b0;
  always @(negedge clk_i) begin
    out_w.ready <= rst_ni && $urandom_range(0, 99) >= snk_idle_pct;
  end

  // Give up after too long without a word moving on either side
  always @(posedge clk_i) begin
    if (!rst_ni || (in_w.valid && in_w.ready) || (out_w.valid && out_w.ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("Timeout: nothing moved for %0d cycles, %0d results outstanding",
                 STALL_LIMIT, pending);
        $display("CHECKS FAILED");
        $finish;
      end
    end
  end

  // Present one word and hold it until taken
  task automatic send_word(input logic [OpW-1:0] op, input logic [ByteW-1:0] data,
                           input logic [CountW-1:0] amt);
    @(negedge clk_i);
    while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
      in_w.valid = 1'b0;
      @(negedge clk_i);
    end
    in_w.valid     = 1'b1;
    in_w.operation = op;
    in_w.byte_in   = data;
    in_w.amount    = amt;
    do @(posedge clk_i); while (!in_w.ready);
    op_seen[op]++;
    words_sent++;
  endtask

  // Hold the input side off until every result has come back
  task automatic wait_drained();
    @(negedge clk_i);
    in_w.valid = 1'b0;
    while (pending != 0) @(negedge clk_i);
  endtask

  function automatic logic [CountW-1:0] pick_amount(input bit for_skip);
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 65) return for_skip ? CountW'($urandom_range(1, 8)) : CountW'($urandom_range(0, 31));
    if (p < 92) return CountW'($urandom_range(0, DEPTH));
    return CountW'(DEPTH);
  endfunction

  function automatic logic [OpW-1:0] pick_op(input int mix);
    int unsigned p, w_enq, w_deq, w_peek, w_skip, w_clr;
    case (mix)
      MIX_DRAIN: begin w_enq = 15; w_deq = 40; w_peek = 25; w_skip = 15; w_clr = 1; end
      MIX_FILL:  begin w_enq = 75; w_deq = 10; w_peek = 10; w_skip = 3;  w_clr = 1; end
      default:   begin w_enq = 45; w_deq = 30; w_peek = 15; w_skip = 7;  w_clr = 1; end
    endcase
    p = $urandom_range(0, 99);
    if (p < w_enq) return OP_ENQ;
    p -= w_enq;
    if (p < w_deq) return OP_DEQ;
    p -= w_deq;
    if (p < w_peek) return OP_PEEK;
    p -= w_peek;
    if (p < w_skip) return OP_SKIP;
    p -= w_skip;
    if (p < w_clr) return OP_CLEAR;
    return OP_SPARE_FIRST + OpW'($urandom_range(0, OP_SPARE_LAST - OP_SPARE_FIRST));
  endfunction

  task automatic send_random(input logic [OpW-1:0] op);
    send_word(op, ByteW'($urandom_range(0, 255)), pick_amount(op == OP_SKIP));
  endtask

  initial begin
    int unsigned enq_sent;
    int unsigned burst_len;
    int          mix;
    logic [OpW-1:0] op;

    in_w.valid     = 1'b0;
    in_w.operation = OP_ENQ;
    in_w.byte_in   = '0;
    in_w.amount    = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: empty-buffer cases, byte extremes, back-to-back enqueue and
    // dequeue of one slot, peek and skip at and past the fill level, clear
    send_word(OP_DEQ,   8'h00, 11'd0);
    send_word(OP_PEEK,  8'h00, 11'd0);
    send_word(OP_SKIP,  8'h00, 11'd5);
    send_word(OP_ENQ,   8'h00, 11'd0);
    send_word(OP_DEQ,   8'h00, 11'd0);
    send_word(OP_ENQ,   8'hFF, 11'd2047);
    send_word(OP_ENQ,   8'hA5, 11'd0);
    send_word(OP_ENQ,   8'h5A, 11'd0);
    send_word(OP_PEEK,  8'h00, 11'd0);
    send_word(OP_PEEK,  8'h00, 11'd2);
    send_word(OP_PEEK,  8'h00, 11'd3);
    send_word(OP_PEEK,  8'h00, 11'd1024);
    send_word(OP_SKIP,  8'h00, 11'd0);
    send_word(OP_SKIP,  8'h00, 11'd1);
    send_word(OP_DEQ,   8'h00, 11'd0);
    send_word(OP_ENQ,   8'h01, 11'd0);
    send_word(OP_SKIP,  8'h00, 11'd1024);
    send_word(OP_SPARE_FIRST, 8'hFF, 11'd1024);
    send_word(OP_ENQ,   8'h80, 11'd0);
    send_word(OP_ENQ,   8'h7F, 11'd0);
    send_word(OP_SPARE_LAST,  8'h55, 11'd1023);
    send_word(OP_CLEAR, 8'hFF, 11'd1024);
    send_word(OP_PEEK,  8'h00, 11'd0);
    send_word(OP_DEQ,   8'h00, 11'd0);
    wait_drained();

    // Fill to full and beyond; the first stretch runs without idling
    enq_sent = 0;
    while (enq_sent < DEPTH + 8) begin
      src_idle_pct = (enq_sent < 400) ? 0 : 33;
      snk_idle_pct = (enq_sent < 400) ? 0 : 33;
      if ($urandom_range(0, 99) < 90) begin
        send_random(OP_ENQ);
        enq_sent++;
      end else begin
        send_random(OP_PEEK);
      end
    end
    wait_drained();

    // Mixed bursts: drain from full, wrap both indices, refill
    while (words_sent < WORD_TARGET) begin
      mix       = $urandom_range(MIX_DRAIN, MIX_FILL);
      burst_len = $urandom_range(40, 120);
      repeat (burst_len) begin
        op = pick_op(mix);
        send_random(op);
      end
    end
    wait_drained();
    repeat (8) @(posedge clk_i);

    $display("Sent %0d words: %0d enqueue, %0d dequeue, %0d peek, %0d skip, %0d clear, %0d spare",
             words_sent, op_seen[OP_ENQ], op_seen[OP_DEQ], op_seen[OP_PEEK],
             op_seen[OP_SKIP], op_seen[OP_CLEAR],
             op_seen[5] + op_seen[6] + op_seen[7]);
    $display("Compared %0d result words; %0d enqueues refused on a full buffer",
             compared, full_refusals);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
